/* design/vector_tile_geometry_decoder_assert.svh */
// Assertion macros for the geometry decoder.
// Define NO_ASSERTIONS to compile them out.
`ifndef VECTOR_TILE_GEOMETRY_DECODER_ASSERT_SVH
`define VECTOR_TILE_GEOMETRY_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define VTGD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtgd same-cycle check failed");

// Next-cycle implication, checked outside reset
`define VTGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtgd next-cycle check failed");

`else

`define VTGD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define VTGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/vtgd_pkg.sv */
`timescale 1ns / 1ps

package vtgd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 29;
    localparam int unsigned ID_W    = 3;
    localparam int unsigned KIND_W  = 2;

    // Command ids in the low bits of a command word
    localparam logic [ID_W-1:0] ID_MOVE  = 3'd1;
    localparam logic [ID_W-1:0] ID_LINE  = 3'd2;
    localparam logic [ID_W-1:0] ID_CLOSE = 3'd7;

    // Point kinds on the result channel
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

    // Active command while parameter words are consumed
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_LINE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              eof;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [KIND_W-1:0] kind;
        logic              done;
    } point_t;

    typedef struct packed {
        cmd_t cmd;
        logic awaiting_dy;
        logic ring_open;
    } step_status_t;

    // Zigzag decode: 0,1,2,3 -> 0,-1,1,-2
    function automatic logic [WORD_W-1:0] unzig(input logic [WORD_W-1:0] v);
        return (v >> 1) ^ {WORD_W{v[0]}};
    endfunction

endpackage

/* design/vtgd_in_stage.sv */
`timescale 1ns / 1ps

module vtgd_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vtgd_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output vtgd_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    vtgd_pkg::item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    // Hold the item until the decode step consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* design/vtgd_step.sv */
`timescale 1ns / 1ps

module vtgd_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  vtgd_pkg::item_t       item,
    output logic                  emit,
    output vtgd_pkg::point_t      point,
    output vtgd_pkg::step_status_t status
);

    logic [vtgd_pkg::WORD_W-1:0]  cursor_x_reg, cursor_x_next;
    logic [vtgd_pkg::WORD_W-1:0]  cursor_y_reg, cursor_y_next;
    vtgd_pkg::cmd_t               cmd_reg, cmd_next;
    logic [vtgd_pkg::COUNT_W-1:0] pairs_reg, pairs_next;
    logic                         awaiting_reg, awaiting_next;
    logic [vtgd_pkg::WORD_W-1:0]  held_dx_reg, held_dx_next;
    logic                         ring_open_reg, ring_open_next;
    logic [vtgd_pkg::WORD_W-1:0]  first_x_reg, first_x_next;
    logic [vtgd_pkg::WORD_W-1:0]  first_y_reg, first_y_next;

    logic [vtgd_pkg::ID_W-1:0]    id;
    logic [vtgd_pkg::COUNT_W-1:0] count;
    logic [vtgd_pkg::WORD_W-1:0]  sum_x;
    logic [vtgd_pkg::WORD_W-1:0]  sum_y;
    logic [vtgd_pkg::COUNT_W-1:0] pairs_dec;

    assign id        = item.word[vtgd_pkg::ID_W-1:0];
    assign count     = item.word[vtgd_pkg::WORD_W-1:vtgd_pkg::ID_W];
    assign sum_x     = cursor_x_reg + vtgd_pkg::unzig(held_dx_reg);
    assign sum_y     = cursor_y_reg + vtgd_pkg::unzig(item.word);
    assign pairs_dec = pairs_reg - {{(vtgd_pkg::COUNT_W-1){1'b0}}, 1'b1};

    // Decode one word against the current command state
    always_comb begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        cmd_next       = cmd_reg;
        pairs_next     = pairs_reg;
        awaiting_next  = awaiting_reg;
        held_dx_next   = held_dx_reg;
        ring_open_next = ring_open_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        emit           = 1'b0;
        point.x        = cursor_x_reg;
        point.y        = cursor_y_reg;
        point.kind     = vtgd_pkg::KIND_START;
        point.done     = item.eof;

        case (cmd_reg)
            vtgd_pkg::CMD_NONE: begin
                if ((id == vtgd_pkg::ID_MOVE || id == vtgd_pkg::ID_LINE) &&
                    count != '0) begin
                    cmd_next      = (id == vtgd_pkg::ID_MOVE) ? vtgd_pkg::CMD_MOVE
                                                              : vtgd_pkg::CMD_LINE;
                    pairs_next    = count;
                    awaiting_next = 1'b0;
                end else if (id == vtgd_pkg::ID_CLOSE && ring_open_reg) begin
                    emit       = 1'b1;
                    point.x    = first_x_reg;
                    point.y    = first_y_reg;
                    point.kind = vtgd_pkg::KIND_CLOSE;
                end
            end
            vtgd_pkg::CMD_MOVE, vtgd_pkg::CMD_LINE: begin
                if (!awaiting_reg) begin
                    held_dx_next  = item.word;
                    awaiting_next = 1'b1;
                end else begin
                    cursor_x_next = sum_x;
                    cursor_y_next = sum_y;
                    awaiting_next = 1'b0;
                    point.x       = sum_x;
                    point.y       = sum_y;
                    if (cmd_reg == vtgd_pkg::CMD_MOVE) begin
                        ring_open_next = 1'b1;
                        first_x_next   = sum_x;
                        first_y_next   = sum_y;
                        emit           = 1'b1;
                        point.kind     = vtgd_pkg::KIND_START;
                    end else if (ring_open_reg) begin
                        emit       = 1'b1;
                        point.kind = vtgd_pkg::KIND_LINE;
                    end
                    pairs_next = pairs_dec;
                    if (pairs_dec == '0) begin
                        cmd_next = vtgd_pkg::CMD_NONE;
                    end
                end
            end
            default: begin
                cmd_next = vtgd_pkg::CMD_NONE;
            end
        endcase

        // End of feature: drop everything, including a dangling dx
        if (item.eof) begin
            cursor_x_next  = '0;
            cursor_y_next  = '0;
            cmd_next       = vtgd_pkg::CMD_NONE;
            pairs_next     = '0;
            awaiting_next  = 1'b0;
            held_dx_next   = '0;
            ring_open_next = 1'b0;
            first_x_next   = '0;
            first_y_next   = '0;
        end
    end

    // Advance the decoder state on each consumed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            cmd_reg       <= vtgd_pkg::CMD_NONE;
            pairs_reg     <= '0;
            awaiting_reg  <= 1'b0;
            held_dx_reg   <= '0;
            ring_open_reg <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
        end else if (fire) begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            cmd_reg       <= cmd_next;
            pairs_reg     <= pairs_next;
            awaiting_reg  <= awaiting_next;
            held_dx_reg   <= held_dx_next;
            ring_open_reg <= ring_open_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
        end
    end

    assign status.cmd         = cmd_reg;
    assign status.awaiting_dy = awaiting_reg;
    assign status.ring_open   = ring_open_reg;

endmodule

/* design/vtgd_out_stage.sv */
`timescale 1ns / 1ps

module vtgd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic             emit,
    input  vtgd_pkg::point_t point,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output vtgd_pkg::point_t m_point
);

    logic             valid_reg;
    logic             valid_next;
    vtgd_pkg::point_t point_reg;

    // Room for a new result when empty or when the held one transfers now
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = emit;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // Hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load && emit) begin
            point_reg <= point;
        end
    end

    assign m_valid = valid_reg;
    assign m_point = point_reg;

endmodule

/* design/vector_tile_geometry_decoder.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_geom_word[31:0], s_end_of_feature
// m_        out        m_valid/m_ready    m_point_x, m_point_y, m_point_kind, m_feature_done
//
// One word per cycle unless m_ready stalls; words pass the input, then the result register.
// The rate is set by the single decode step between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and clears the cursor and ring.
// A stalled result port holds the decode step; one word more waits in the input register.

`include "vector_tile_geometry_decoder_assert.svh"

module vector_tile_geometry_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_geom_word,
    input  logic               s_end_of_feature,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic [1:0]         m_point_kind,
    output logic               m_feature_done
);

    vtgd_pkg::item_t        s_item;
    vtgd_pkg::item_t        item;
    logic                   item_valid;
    logic                   out_free;
    logic                   fire;
    logic                   emit;
    vtgd_pkg::point_t       point;
    vtgd_pkg::point_t       m_point;
    vtgd_pkg::step_status_t status;

    assign s_item.word = s_geom_word;
    assign s_item.eof  = s_end_of_feature;

    // Consume the held word whenever the result register can take its outcome
    assign fire = item_valid && out_free;

    vtgd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    vtgd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .emit    (emit),
        .point   (point),
        .status  (status)
    );

    vtgd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire),
        .emit    (emit),
        .point   (point),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_point (m_point)
    );

    assign m_point_x      = $signed(m_point.x);
    assign m_point_y      = $signed(m_point.y);
    assign m_point_kind   = m_point.kind;
    assign m_feature_done = m_point.done;

    // A shown point never carries the unused kind code
    `VTGD_ASSERT_IMPLY(a_kind_legal, aclk, aresetn, m_valid, m_point_kind != 2'd3)
    // A pending dy only exists inside a MoveTo or LineTo run
    `VTGD_ASSERT_IMPLY(a_dy_in_run, aclk, aresetn, status.awaiting_dy,
        status.cmd != vtgd_pkg::CMD_NONE)
    // End of feature leaves the decoder waiting for a fresh command with no ring
    `VTGD_ASSERT_NEXT(a_eof_clears, aclk, aresetn, fire && item.eof,
        status.cmd == vtgd_pkg::CMD_NONE && !status.ring_open && !status.awaiting_dy)
    // Backpressure on the input only comes from a full input register
    `VTGD_ASSERT_IMPLY(a_ready_src, aclk, aresetn, !s_ready, item_valid && !out_free)

endmodule

/* tb/sv/vtgd_point_checker.sv */
`timescale 1ns / 1ps

module vtgd_point_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [31:0]        s_geom_word,
    input  logic               s_end_of_feature,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_point_x,
    input  logic signed [31:0] m_point_y,
    input  logic [1:0]         m_point_kind,
    input  logic               m_feature_done,
    output int                 mismatch_count,
    output int                 points_outstanding
);

    import vtgd_pkg::*;

    // Predicted decoder state
    logic [WORD_W-1:0]  pos_x;
    logic [WORD_W-1:0]  pos_y;
    cmd_t               cur_cmd;
    logic [COUNT_W-1:0] pairs_left;
    logic               want_dy;
    logic [WORD_W-1:0]  held_dx;
    logic               ring_open;
    logic [WORD_W-1:0]  ring_x;
    logic [WORD_W-1:0]  ring_y;

    point_t expected_points[$];
    point_t want;
    int     errors_seen = 0;

    // Map a zigzag word back to its two's complement delta
    function automatic logic [WORD_W-1:0] zigzag_delta(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] mag;
        mag = {1'b0, v[WORD_W-1:1]};
        return v[0] ? ~mag : mag;
    endfunction

    task automatic clear_cursor();
        pos_x      = '0;
        pos_y      = '0;
        cur_cmd    = CMD_NONE;
        pairs_left = '0;
        want_dy    = 1'b0;
        held_dx    = '0;
        ring_open  = 1'b0;
        ring_x     = '0;
        ring_y     = '0;
    endtask

    // Advance the predicted state by one geometry word
    task automatic decode_word(input logic [WORD_W-1:0] w, input logic eof);
        point_t             pt;
        logic               emit;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
        emit    = 1'b0;
        pt.done = eof;
        id      = w[ID_W-1:0];
        count   = w[WORD_W-1:ID_W];
        if (cur_cmd == CMD_NONE) begin
            if ((id == ID_MOVE || id == ID_LINE) && count != '0) begin
                cur_cmd    = (id == ID_MOVE) ? CMD_MOVE : CMD_LINE;
                pairs_left = count;
                want_dy    = 1'b0;
            end else if (id == ID_CLOSE && ring_open) begin
                pt.x    = ring_x;
                pt.y    = ring_y;
                pt.kind = KIND_CLOSE;
                emit    = 1'b1;
            end
        end else if (!want_dy) begin
            held_dx = w;
            want_dy = 1'b1;
        end else begin
            pos_x   = pos_x + zigzag_delta(held_dx);
            pos_y   = pos_y + zigzag_delta(w);
            want_dy = 1'b0;
            pt.x    = pos_x;
            pt.y    = pos_y;
            if (cur_cmd == CMD_MOVE) begin
                ring_open = 1'b1;
                ring_x    = pos_x;
                ring_y    = pos_y;
                pt.kind   = KIND_START;
                emit      = 1'b1;
            end else if (ring_open) begin
                pt.kind = KIND_LINE;
                emit    = 1'b1;
            end
            pairs_left = pairs_left - COUNT_W'(1);
            if (pairs_left == '0) begin
                cur_cmd = CMD_NONE;
            end
        end
        if (emit) begin
            expected_points = {expected_points, pt};
        end
        // End of feature drops everything, a pending dx included
        if (eof) begin
            clear_cursor();
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                               input logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
            errors_seen++;
        end
    endtask

    // Predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_cursor();
            expected_points.delete();
        end else begin
            if (s_valid && s_ready) begin
                decode_word(s_geom_word, s_end_of_feature);
            end
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $error("point_x: expected no point, got 0x%08h", m_point_x);
                    errors_seen++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("point_x", want.x, m_point_x);
                    check_field("point_y", want.y, m_point_y);
                    check_field("point_kind", 32'(want.kind), 32'(m_point_kind));
                    check_field("feature_done", 32'(want.done), 32'(m_feature_done));
                end
            end
        end
        mismatch_count     <= errors_seen;
        points_outstanding <= expected_points.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import vtgd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 200;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [31:0]        s_geom_word;
    logic               s_end_of_feature;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_point_x;
    logic signed [31:0] m_point_y;
    logic [1:0]         m_point_kind;
    logic               m_feature_done;

    int mismatch_count;
    int points_outstanding;

    int phase         = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;
    int hold_count    = 0;
    int cycle_count   = 0;

    logic [31:0] feature_words[$];

    vector_tile_geometry_decoder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_geom_word      (s_geom_word),
        .s_end_of_feature (s_end_of_feature),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_x        (m_point_x),
        .m_point_y        (m_point_y),
        .m_point_kind     (m_point_kind),
        .m_feature_done   (m_feature_done)
    );

    vtgd_point_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_geom_word        (s_geom_word),
        .s_end_of_feature   (s_end_of_feature),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_point_x          (m_point_x),
        .m_point_y          (m_point_y),
        .m_point_kind       (m_point_kind),
        .m_feature_done     (m_feature_done),
        .mismatch_count     (mismatch_count),
        .points_outstanding (points_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random back-pressure, one long hold-off when the last phase opens
    always @(posedge aclk) begin
        if (phase == 3 && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [31:0] cmd_word(input logic [ID_W-1:0] id,
                                             input logic [COUNT_W-1:0] count);
        return {count, id};
    endfunction

    function automatic logic [31:0] to_zigzag(input int d);
        return (d << 1) ^ (d >>> 31);
    endfunction

    function automatic logic [31:0] rand_delta_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return to_zigzag(int'($urandom_range(128)) - 64);
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
            default: return to_zigzag(int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] unknown_id();
        logic [ID_W-1:0] id;
        do begin
            id = ID_W'($urandom_range(7));
        end while (id == ID_MOVE || id == ID_LINE || id == ID_CLOSE);
        return id;
    endfunction

    // Offer one word, idling first at the current rate, and hold it until the transfer
    task automatic send_word(input logic [31:0] w, input logic eof);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_geom_word <= $urandom;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_valid          <= 1'b1;
        s_geom_word      <= w;
        s_end_of_feature <= eof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic add_pairs(input logic [ID_W-1:0] id, input int count);
        feature_words = {feature_words, cmd_word(id, COUNT_W'(count))};
        repeat (2 * count) feature_words = {feature_words, rand_delta_word()};
    endtask

    // Build one feature, mostly well formed, sometimes noise or cut short
    task automatic send_feature();
        logic [31:0] w;
        int          keep;
        feature_words.delete();
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 8)) begin
                w = $urandom;
                case ($urandom_range(4))
                    0: w[ID_W-1:0] = unknown_id();
                    1: w = cmd_word($urandom_range(1) ? ID_MOVE : ID_LINE, '0);
                    2: w[ID_W-1:0] = ID_CLOSE;
                    3: w[ID_W-1:0] = $urandom_range(1) ? ID_MOVE : ID_LINE;
                    default: ;
                endcase
                feature_words = {feature_words, w};
            end
        end else begin
            if ($urandom_range(9) == 0) begin
                add_pairs(ID_LINE, $urandom_range(1, 2));
            end
            repeat ($urandom_range(1, 3)) begin
                add_pairs(ID_MOVE, ($urandom_range(4) == 0) ? $urandom_range(2, 3) : 1);
                add_pairs(ID_LINE, $urandom_range(1, 5));
                if ($urandom_range(9) < 7) begin
                    w = $urandom;
                    if ($urandom_range(1)) begin
                        w[31:ID_W] = COUNT_W'(1);
                    end
                    w[ID_W-1:0] = ID_CLOSE;
                    feature_words = {feature_words, w};
                end
            end
        end
        if ($urandom_range(4) == 0) begin
            keep = $urandom_range(1, feature_words.size());
            while (feature_words.size() > keep) void'(feature_words.pop_back());
        end
        foreach (feature_words[i]) begin
            send_word(feature_words[i], i == feature_words.size() - 1);
        end
    endtask

    initial begin
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_geom_word      <= '0;
        s_end_of_feature <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn       <= 1'b1;
        phase         <= 1;
        send_idle_pct <= 20;
        recv_idle_pct <= 79;
        @(posedge aclk);

        // Close with no ring open
        send_word(cmd_word(ID_CLOSE, 1), 1'b0);
        // Line before any ring: cursor moves, nothing comes out
        send_word(cmd_word(ID_LINE, 1), 1'b0);
        send_word(to_zigzag(5), 1'b0);
        send_word(to_zigzag(-7), 1'b0);
        // Zero counts fall back to command reading
        send_word(cmd_word(ID_MOVE, 0), 1'b0);
        send_word(cmd_word(ID_LINE, 0), 1'b0);
        // Unknown ids are skipped
        for (int id = 0; id < 8; id++) begin
            if (id != ID_MOVE && id != ID_LINE && id != ID_CLOSE) begin
                send_word(cmd_word(ID_W'(id), COUNT_W'(id + 1)), 1'b0);
            end
        end
        // Extreme deltas, cursor wraps
        send_word(cmd_word(ID_MOVE, 1), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        send_word(cmd_word(ID_LINE, 2), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        // Close with the largest count
        send_word(cmd_word(ID_CLOSE, '1), 1'b0);
        // End of feature on a dx drops it
        send_word(cmd_word(ID_MOVE, 1), 1'b0);
        send_word(32'hFFFF_FFFE, 1'b1);
        // End-of-feature word with nothing to emit
        send_word(cmd_word(ID_CLOSE, 1), 1'b1);
        // Point on the end-of-feature word
        send_word(cmd_word(ID_MOVE, 1), 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'h7FFF_FFFE, 1'b1);

        while (words_sent < 25 + PHASE_ITEMS) send_feature();

        phase         <= 2;
        send_idle_pct <= 79;
        recv_idle_pct <= 20;
        while (words_sent < 25 + 2 * PHASE_ITEMS) send_feature();

        phase         <= 3;
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        while (words_sent < 25 + 3 * PHASE_ITEMS) send_feature();

        s_valid <= 1'b0;
        repeat (4) @(posedge aclk);
        while (points_outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0 && points_outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* vector_tile_geometry_decoder.f */
+incdir+design
design/vtgd_pkg.sv
design/vtgd_in_stage.sv
design/vtgd_step.sv
design/vtgd_out_stage.sv
design/vector_tile_geometry_decoder.sv
tb/sv/vtgd_point_checker.sv
tb/sv/testbench.sv
